FILE: src/neuron_adaptation_unit_assert.svh
// assertion macros shared by the neuron adaptation unit checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef NEURON_ADAPTATION_UNIT_ASSERT_SVH
`define NEURON_ADAPTATION_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define NAU_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("neuron adaptation unit: property violated");

// consequent holds in the same cycle as the antecedent
`define NAU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("neuron adaptation unit: property violated");

// consequent holds in the cycle after the antecedent
`define NAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("neuron adaptation unit: property violated");

`endif

FILE: src/nau_pkg.sv
// types, constants and helper functions of the neuron adaptation unit
// used by nau_cfg_regs, neuron_adaptation_unit, nau_checker and the testbench; no dependencies
`timescale 1ns / 1ps

package nau_pkg;

  localparam int unsigned ValueWidth    = 16;
  localparam int unsigned FracBits      = 12;
  localparam int unsigned OneQ          = 1 << FracBits;
  localparam int unsigned IndexWidth    = 8;
  localparam int unsigned IndexRange    = 1 << IndexWidth;
  localparam int unsigned NearZeroWidth = 15;
  localparam int unsigned DecayFactor   = 5;

  // stream payload widths
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 32;

  // apb port
  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 32;

  // datapath widths
  localparam int unsigned WideWidth  = ValueWidth + 1;          // v - bias, 1 - v, |x|
  localparam int unsigned ProdWidth  = 2 * WideWidth;           // (1 - v) * rate
  localparam int unsigned FeatWidth  = ProdWidth;               // v * one - (1 - v) * rate
  localparam int unsigned Prod2Width = ValueWidth + FeatWidth;  // amp * feature term
  localparam int unsigned GainWidth  = ValueWidth + 4;          // rate or rate * 5
  localparam int unsigned BaseWidth  = 2 * ValueWidth;          // amp * rate
  localparam int unsigned LoopWidth  = ValueWidth + GainWidth + 2;
  localparam int unsigned DeltaWidth = LoopWidth - FracBits;
  localparam int unsigned SatWidth   = DeltaWidth + 1;

  localparam logic signed [SatWidth-1:0] SatMax = SatWidth'((2 ** (ValueWidth - 1)) - 1);
  localparam logic signed [SatWidth-1:0] SatMin = SatWidth'(-(2 ** (ValueWidth - 1)));

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [1:0] {
    ModeStandard  = 2'd0,
    ModeMinusBias = 2'd1,
    ModeFeature   = 2'd2
  } mode_e;

  typedef enum logic {
    FuncApply  = 1'b0,
    FuncUpdate = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    RegEnable    = 3'd0,
    RegMode      = 3'd1,
    RegAmplitude = 3'd2,
    RegRate      = 3'd3,
    RegNearZero  = 3'd4
  } cfg_reg_e;

  // register contents plus values derived from them
  typedef struct packed {
    logic                          enable;
    logic [1:0]                    mode;
    value_t                        amplitude;
    value_t                        rate;
    logic [NearZeroWidth-1:0]      near_zero;
    logic                          sub_thresh;
    logic signed [BaseWidth-1:0]   base;
    logic signed [GainWidth-1:0]   rate5;
  } cfg_t;

  function automatic logic [WideWidth-1:0] mag_value(input value_t x);
    logic signed [WideWidth-1:0] xe;
    xe = WideWidth'(x);
    mag_value = xe[WideWidth-1] ? -xe : xe;
  endfunction

  function automatic value_t sat_value(input logic signed [SatWidth-1:0] x);
    sat_value = x[ValueWidth-1:0];
    if (x > SatMax) begin
      sat_value = {1'b0, {(ValueWidth - 1){1'b1}}};
    end else if (x < SatMin) begin
      sat_value = {1'b1, {(ValueWidth - 1){1'b0}}};
    end
  endfunction

endpackage

FILE: src/neuron_adaptation_unit.sv
// Neuron adaptation unit: a five-register pipeline that takes one item per clock cycle and
// shows its result after these registers in order (accept register, feature-term
// product, amplitude product, rounding plus store read, then the result register). The
// per-unit adaptation store is read one stage before the last and written as the item
// enters the result register; the value of the item just ahead is forwarded from the
// result register, so consecutive items may name the same unit at full rate. The store
// comes out of reset all zero through per-entry valid bits, with no clearing pass. A
// stalled result stalls the whole pipeline; input ready is low only while a result waits.
// depends on nau_pkg and nau_cfg_regs
`timescale 1ns / 1ps

module neuron_adaptation_unit #(
  parameter int unsigned NUM_UNITS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] unit_index, [23:8] unit_value, [39:24] unit_bias
  input  logic [nau_pkg::InDataWidth-1:0]   s_axis_tdata,
  // [0] func
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] new_value, [31:16] adapt_value
  output logic [nau_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nau_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [nau_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [nau_pkg::CfgDataWidth-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned Depth = (NUM_UNITS < nau_pkg::IndexRange) ? NUM_UNITS
                                                                    : nau_pkg::IndexRange;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned VW    = nau_pkg::ValueWidth;
  localparam int unsigned WW    = nau_pkg::WideWidth;

  nau_pkg::cfg_t cfg;

  nau_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // ---------------------------------------------------------------- index fold
  logic [IdxW-1:0] idx_lut [nau_pkg::IndexRange];

  for (genvar g = 0; g < nau_pkg::IndexRange; g++) begin : g_idx_lut
    assign idx_lut[g] = IdxW'(g % Depth);
  end

  // ---------------------------------------------------------------- flow control
  logic advance;
  logic m_vld_q;

  assign advance       = !m_vld_q || m_axis_tready;
  assign s_axis_tready = advance;

  // ---------------------------------------------------------------- input decode
  logic                                  in_upd;
  logic [nau_pkg::IndexWidth-1:0]        in_unit;
  nau_pkg::value_t                       in_v;
  nau_pkg::value_t                       in_bias;
  logic signed [WW-1:0]                  in_vb;
  logic signed [WW-1:0]                  one_minus_v;
  logic signed [nau_pkg::ProdWidth-1:0]  in_prod;
  logic                                  in_decay;

  always_comb begin
    in_upd   = (s_axis_tuser[0] == nau_pkg::FuncUpdate);
    in_unit  = s_axis_tdata[nau_pkg::IndexWidth-1:0];
    in_v     = s_axis_tdata[nau_pkg::IndexWidth +: VW];
    in_bias  = s_axis_tdata[nau_pkg::IndexWidth + VW +: VW];
    if (cfg.mode == nau_pkg::ModeMinusBias) begin
      in_vb = WW'(in_v) - WW'(in_bias);
    end else begin
      in_vb = WW'(in_v);
    end
    one_minus_v = WW'(nau_pkg::OneQ) - WW'(in_v);
    in_prod     = one_minus_v * WW'($signed(cfg.rate));
    // below the threshold the update decays toward zero, except in feature mode
    in_decay    = nau_pkg::mag_value(in_v) < WW'(cfg.near_zero);
  end

  // ---------------------------------------------------------------- pipeline registers
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;

  logic                                   s1_upd_q, s2_upd_q, s3_upd_q, s4_upd_q;
  logic [IdxW-1:0]                        s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  nau_pkg::value_t                        s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic signed [WW-1:0]                   s1_vb_q, s2_vb_q, s3_vb_q, s4_vb_q;
  logic                                   s1_decay_q, s2_decay_q, s3_decay_q, s4_decay_q;
  logic signed [nau_pkg::ProdWidth-1:0]   s1_prod_q;
  logic signed [nau_pkg::FeatWidth-1:0]   s2_feat_q, s2_feat_d;
  logic signed [nau_pkg::Prod2Width-1:0]  s3_prod2_q, s3_prod2_d, s3_round;
  logic signed [nau_pkg::DeltaWidth-1:0]  s4_delta2_q;
  nau_pkg::value_t                        mem_rd_q;
  logic                                   ent_hit_q;

  logic [IdxW-1:0]                        m_idx_q;
  nau_pkg::value_t                        m_adapt_q, m_new_q;

  always_comb begin
    s2_feat_d  = (nau_pkg::FeatWidth'(s1_v_q) <<< nau_pkg::FracBits) - s1_prod_q;
    s3_prod2_d = $signed(cfg.amplitude) * s2_feat_q;
    // round to nearest, ties up, back from 2 * frac bits
    s3_round   = s3_prod2_q + (nau_pkg::Prod2Width'(1) <<< (2 * nau_pkg::FracBits - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      m_vld_q  <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_upd_q    <= in_upd;
      s1_idx_q    <= idx_lut[in_unit];
      s1_v_q      <= in_v;
      s1_vb_q     <= in_vb;
      s1_decay_q  <= in_decay;
      s1_prod_q   <= in_prod;

      s2_upd_q    <= s1_upd_q;
      s2_idx_q    <= s1_idx_q;
      s2_v_q      <= s1_v_q;
      s2_vb_q     <= s1_vb_q;
      s2_decay_q  <= s1_decay_q;
      s2_feat_q   <= s2_feat_d;

      s3_upd_q    <= s2_upd_q;
      s3_idx_q    <= s2_idx_q;
      s3_v_q      <= s2_v_q;
      s3_vb_q     <= s2_vb_q;
      s3_decay_q  <= s2_decay_q;
      s3_prod2_q  <= s3_prod2_d;

      s4_upd_q    <= s3_upd_q;
      s4_idx_q    <= s3_idx_q;
      s4_v_q      <= s3_v_q;
      s4_vb_q     <= s3_vb_q;
      s4_decay_q  <= s3_decay_q;
      s4_delta2_q <= s3_round[nau_pkg::Prod2Width-1:2 * nau_pkg::FracBits];
    end
  end

  // ---------------------------------------------------------------- adaptation store
  nau_pkg::value_t store_mem [Depth];
  logic [Depth-1:0] ent_vld_q;
  nau_pkg::value_t a_new;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s4_vld_q) begin
        store_mem[s4_idx_q] <= a_new;
      end
      mem_rd_q  <= store_mem[s3_idx_q];
      ent_hit_q <= ent_vld_q[s3_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (advance && s4_vld_q) begin
      ent_vld_q[s4_idx_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- read-modify-write stage
  nau_pkg::value_t                        a_cur;
  logic signed [nau_pkg::GainWidth-1:0]   gain;
  logic signed [nau_pkg::BaseWidth-1:0]   base;
  logic signed [VW+nau_pkg::GainWidth-1:0] mprod;
  logic signed [nau_pkg::LoopWidth-1:0]   loop_sum;
  logic signed [nau_pkg::DeltaWidth-1:0]  delta;
  logic signed [nau_pkg::SatWidth-1:0]    a_sum;
  logic signed [nau_pkg::SatWidth-1:0]    diff;
  nau_pkg::value_t                        new_val;

  always_comb begin
    // the item just ahead wrote at the same edge this one read, so take its result
    if (m_vld_q && (m_idx_q == s4_idx_q)) begin
      a_cur = m_adapt_q;
    end else if (ent_hit_q) begin
      a_cur = mem_rd_q;
    end else begin
      a_cur = '0;
    end

    if (s4_decay_q) begin
      gain = cfg.rate5;
      base = '0;
    end else begin
      gain = nau_pkg::GainWidth'($signed(cfg.rate));
      base = cfg.base;
    end

    // (amp - a) * rate, or -a * rate * 5, rounded back to frac bits
    mprod    = $signed(a_cur) * gain;
    loop_sum = nau_pkg::LoopWidth'(base) - nau_pkg::LoopWidth'(mprod)
             + (nau_pkg::LoopWidth'(1) <<< (nau_pkg::FracBits - 1));

    if (cfg.mode == nau_pkg::ModeFeature) begin
      delta = s4_delta2_q;
    end else begin
      delta = loop_sum[nau_pkg::LoopWidth-1:nau_pkg::FracBits];
    end

    a_sum = nau_pkg::SatWidth'($signed(a_cur)) + nau_pkg::SatWidth'(delta);
    if (s4_upd_q && cfg.enable) begin
      a_new = nau_pkg::sat_value(a_sum);
    end else begin
      a_new = a_cur;
    end

    diff = nau_pkg::SatWidth'(s4_vb_q) - nau_pkg::SatWidth'($signed(a_cur));
    if (!s4_upd_q && cfg.enable && !cfg.sub_thresh) begin
      new_val = nau_pkg::sat_value(diff);
    end else begin
      new_val = s4_v_q;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_idx_q   <= s4_idx_q;
      m_adapt_q <= a_new;
      m_new_q   <= new_val;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {m_adapt_q, m_new_q};

endmodule

FILE: src/nau_cfg_regs.sv
// apb register file of the neuron adaptation unit with derived products
// depends on nau_pkg
`timescale 1ns / 1ps

module nau_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [nau_pkg::CfgAddrWidth-1:0]  paddr_i,
  input  logic [nau_pkg::CfgDataWidth-1:0]  pwdata_i,
  output logic [nau_pkg::CfgDataWidth-1:0]  prdata_o,
  output nau_pkg::cfg_t                     cfg_o
);

  logic                                    wr_en;
  logic [2:0]                              reg_idx;
  logic                                    enable_q;
  logic [1:0]                              mode_q;
  nau_pkg::value_t                         amplitude_q;
  nau_pkg::value_t                         rate_q;
  logic [nau_pkg::NearZeroWidth-1:0]       near_zero_q;
  logic                                    small_q, small_d;
  logic signed [nau_pkg::BaseWidth-1:0]    base_q, base_d;
  logic signed [nau_pkg::GainWidth-1:0]    rate5_q, rate5_d;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = paddr_i[nau_pkg::CfgAddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      mode_q      <= nau_pkg::ModeStandard;
      amplitude_q <= '0;
      rate_q      <= '0;
      near_zero_q <= nau_pkg::NearZeroWidth'(1);
    end else if (wr_en) begin
      case (reg_idx)
        nau_pkg::RegEnable:    enable_q    <= pwdata_i[0];
        nau_pkg::RegMode:      mode_q      <= pwdata_i[1:0];
        nau_pkg::RegAmplitude: amplitude_q <= pwdata_i[nau_pkg::ValueWidth-1:0];
        nau_pkg::RegRate:      rate_q      <= pwdata_i[nau_pkg::ValueWidth-1:0];
        nau_pkg::RegNearZero:  near_zero_q <= pwdata_i[nau_pkg::NearZeroWidth-1:0];
        default: ;
      endcase
    end
  end

  // products of config values and the small-value flag, held in registers that follow each write
  always_comb begin
    base_d  = $signed(amplitude_q) * $signed(rate_q);
    rate5_d = (nau_pkg::GainWidth'($signed(rate_q)) <<< 2)
            + nau_pkg::GainWidth'($signed(rate_q));
    small_d = (nau_pkg::mag_value(amplitude_q) < nau_pkg::WideWidth'(near_zero_q))
           || (nau_pkg::mag_value(rate_q) < nau_pkg::WideWidth'(near_zero_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      rate5_q <= '0;
      small_q <= 1'b1;
    end else begin
      base_q  <= base_d;
      rate5_q <= rate5_d;
      small_q <= small_d;
    end
  end

  always_comb begin
    case (reg_idx)
      nau_pkg::RegEnable:    prdata_o = nau_pkg::CfgDataWidth'(enable_q);
      nau_pkg::RegMode:      prdata_o = nau_pkg::CfgDataWidth'(mode_q);
      nau_pkg::RegAmplitude: prdata_o = nau_pkg::CfgDataWidth'($signed(amplitude_q));
      nau_pkg::RegRate:      prdata_o = nau_pkg::CfgDataWidth'($signed(rate_q));
      nau_pkg::RegNearZero:  prdata_o = nau_pkg::CfgDataWidth'(near_zero_q);
      default:               prdata_o = '0;
    endcase
  end

  assign cfg_o.enable     = enable_q;
  assign cfg_o.mode       = mode_q;
  assign cfg_o.amplitude  = amplitude_q;
  assign cfg_o.rate       = rate_q;
  assign cfg_o.near_zero  = near_zero_q;
  assign cfg_o.sub_thresh = small_q;
  assign cfg_o.base       = base_q;
  assign cfg_o.rate5      = rate5_q;

endmodule

FILE: src/nau_checker.sv
// port-level checker for the neuron adaptation unit, bound to the top level
// depends on nau_pkg and neuron_adaptation_unit_assert.svh
`timescale 1ns / 1ps
`include "neuron_adaptation_unit_assert.svh"

module nau_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [nau_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input logic                              pready
);

  `NAU_ASSERT_HOLDS(ApbAlwaysReady, pready)

  // a waiting result freezes the whole pipeline, input side included
  `NAU_ASSERT_IMPL(StallBlocksInput, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // with the result register empty nothing can hold the input back
  `NAU_ASSERT_IMPL(EmptyTakesInput, !m_axis_tvalid, s_axis_tready)

  `NAU_ASSERT_NEXT(ResultHolds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind neuron_adaptation_unit nau_checker u_nau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

FILE: tb/neuron_adaptation_unit_tb.sv
// self-checking testbench for neuron_adaptation_unit: apply/update stream traffic under
// several register settings and idle patterns, checked against an in-bench predictor
// depends on nau_pkg and neuron_adaptation_unit
`timescale 1ns / 1ps

module neuron_adaptation_unit_tb;
  import nau_pkg::*;

  localparam longint OneQL = OneQ;
  localparam longint DecayL = DecayFactor;
  localparam logic [1:0] ModeSpare = 2'd3;  // unused encoding, acts as standard
  localparam int StallLimit = 2000;

  typedef struct packed {
    func_e       func;
    logic [7:0]  unit;
    value_t      value;
    value_t      bias;
  } unit_item_t;

  typedef struct packed {
    value_t new_value;
    value_t adapt_value;
  } unit_result_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // [7:0] unit_index, [23:8] unit_value, [39:24] unit_bias
  logic [InDataWidth-1:0] s_axis_tdata;
  // [0] func
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // [15:0] new_value, [31:16] adapt_value
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic pready;

  neuron_adaptation_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the register file and of the per-unit adaptation store
  logic                     cfg_enable;
  logic [1:0]               cfg_mode;
  value_t                   cfg_amplitude;
  value_t                   cfg_rate;
  logic [NearZeroWidth-1:0] cfg_near_zero;
  value_t                   adapt_shadow [IndexRange];

  unit_item_t   unit_items_q [$];
  unit_result_t expected_outputs [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  mismatch_count;
  int  stall_cycles;
  bit  input_taken;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint clamp_q(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic longint round_q(input longint x, input int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint mag_q(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  task automatic predict_adaptation(input func_e fn, input logic [7:0] unit,
                                    input value_t v_in, input value_t b_in);
    longint a, amp, rt, v, b, nz, res, delta;
    bit below;
    unit_result_t r;
    a = adapt_shadow[unit];
    amp = cfg_amplitude;
    rt = cfg_rate;
    v = v_in;
    b = b_in;
    nz = cfg_near_zero;
    res = v;
    if (fn == FuncApply) begin
      below = (mag_q(amp) < nz) || (mag_q(rt) < nz);
      if (cfg_enable && !below) begin
        if (cfg_mode == ModeMinusBias) res = clamp_q(v - a - b);
        else res = clamp_q(v - a);
      end
    end else if (cfg_enable) begin
      if (cfg_mode == ModeFeature) begin
        delta = round_q(amp * v * OneQL - (OneQL - v) * amp * rt, 2 * FracBits);
      end else if (mag_q(v) >= nz) begin
        delta = round_q((amp - a) * rt, FracBits);
      end else begin
        delta = round_q(-a * rt * DecayL, FracBits);
      end
      a = clamp_q(a + delta);
      adapt_shadow[unit] = value_t'(a);
    end
    r.new_value = value_t'(res);
    r.adapt_value = value_t'(a);
    expected_outputs.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input unit_result_t exp_r,
                                 input unit_result_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected new_value %0d adapt_value %0d, got new_value %0d adapt_value %0d",
               $realtime, what, exp_r.new_value, exp_r.adapt_value,
               got_r.new_value, got_r.adapt_value);
    end
  endtask

  // input driver: new transaction at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    unit_item_t it;
    if (rst_ni && (!s_axis_tvalid || input_taken)) begin
      if (unit_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = unit_items_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.bias, it.value, it.unit};
        s_axis_tuser  <= it.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    input_taken = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk_i) begin
    unit_result_t got, exp_r;
    bit active;
    if (rst_ni) begin
      active = psel;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_adaptation(func_e'(s_axis_tuser[0]), s_axis_tdata[7:0],
                           s_axis_tdata[23:8], s_axis_tdata[39:24]);
        input_taken = 1'b1;
        active = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        active = 1'b1;
        got.new_value = m_axis_tdata[15:0];
        got.adapt_value = m_axis_tdata[31:16];
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          exp_r = expected_outputs.pop_front();
          if (got.new_value !== exp_r.new_value || got.adapt_value !== exp_r.adapt_value)
            report_mismatch("result mismatch", exp_r, got);
        end
      end
      stall_cycles = active ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("neuron_adaptation_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic cfg_write(input cfg_reg_e reg_idx, input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrWidth'({reg_idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      RegEnable:    cfg_enable = data[0];
      RegMode:      cfg_mode = data[1:0];
      RegAmplitude: cfg_amplitude = data[ValueWidth-1:0];
      RegRate:      cfg_rate = data[ValueWidth-1:0];
      RegNearZero:  cfg_near_zero = data[NearZeroWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic [1:0] md, input value_t amp,
                            input value_t rt, input logic [NearZeroWidth-1:0] nz);
    cfg_write(RegEnable, CfgDataWidth'(en));
    cfg_write(RegMode, CfgDataWidth'(md));
    cfg_write(RegAmplitude, {16'h0, amp});
    cfg_write(RegRate, {16'h0, rt});
    cfg_write(RegNearZero, CfgDataWidth'(nz));
  endtask

  // block is idle once everything queued has come back out
  task automatic wait_drained();
    while (unit_items_q.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic push_item(input func_e fn, input int unit, input int v, input int b);
    unit_item_t it;
    it.func = fn;
    it.unit = unit[7:0];
    it.value = value_t'(v);
    it.bias = value_t'(b);
    unit_items_q.push_back(it);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return value_t'(int'($urandom_range(0, 8)) - 4);
      3: return value_t'(OneQL);
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic push_random(input int count);
    int unit;
    repeat (count) begin
      // mostly a few units so the same entry comes back to back
      unit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      push_item(func_e'($urandom_range(0, 1)), unit, pick_value(), pick_value());
    end
  endtask

  task automatic random_phase(input logic en, input logic [1:0] md, input value_t amp,
                              input value_t rt, input logic [NearZeroWidth-1:0] nz,
                              input int send_pct, input int recv_pct, input int count);
    wait_drained();
    set_config(en, md, amp, rt, nz);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    push_random(count);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_enable = 1'b1;
    cfg_mode = ModeStandard;
    cfg_amplitude = '0;
    cfg_rate = '0;
    cfg_near_zero = 1;
    foreach (adapt_shadow[i]) adapt_shadow[i] = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    stall_cycles = 0;
    input_taken = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero amplitude and rate, store reads zero
    push_item(FuncApply, 0, 1000, 0);
    push_item(FuncUpdate, 3, 4096, 0);
    wait_drained();

    // standard mode: relax toward amplitude, then decay, same unit back to back
    set_config(1'b1, ModeStandard, 16'sd2048, 16'sd410, 1);
    push_item(FuncUpdate, 0, 4096, 0);
    push_item(FuncUpdate, 0, 4096, 0);
    push_item(FuncUpdate, 0, 0, 0);
    push_item(FuncApply, 0, 32767, 0);
    push_item(FuncApply, 0, -32768, 0);
    push_item(FuncUpdate, 255, -32768, 0);
    wait_drained();

    // minus-bias mode with extreme amplitude and rate, threshold zero
    set_config(1'b1, ModeMinusBias, -16'sd32768, 16'sd32767, 0);
    push_item(FuncApply, 255, -32768, 32767);
    push_item(FuncApply, 255, 32767, -32768);
    push_item(FuncUpdate, 255, 32767, -1);
    push_item(FuncApply, 255, 0, 0);
    wait_drained();

    // feature extraction: v equal to one, and the value extremes
    set_config(1'b1, ModeFeature, 16'sd32767, -16'sd32768, 0);
    push_item(FuncUpdate, 1, 4096, 0);
    push_item(FuncUpdate, 1, 32767, 0);
    push_item(FuncUpdate, 1, -32768, 0);
    push_item(FuncApply, 1, 100, 0);
    wait_drained();

    // spare mode code, threshold at maximum: apply passes, updates below it decay
    set_config(1'b1, ModeSpare, 16'sd1000, 16'sd300, 15'h7fff);
    push_item(FuncApply, 1, 1234, 5);
    push_item(FuncUpdate, 1, 100, 0);
    push_item(FuncUpdate, 1, -32768, 0);
    wait_drained();

    // disabled: pass-through and store untouched
    set_config(1'b0, ModeFeature, 16'sd2048, 16'sd410, 1);
    push_item(FuncApply, 1, -777, 3);
    push_item(FuncUpdate, 1, 4096, 0);

    random_phase(1'b1, ModeStandard, 16'sd2048, 16'sd410, 1, 0, 0, 110);
    random_phase(1'b1, ModeMinusBias, value_t'($urandom()), value_t'($urandom()),
                 NearZeroWidth'($urandom_range(0, 64)), 56, 0, 110);
    random_phase(1'b1, ModeFeature, 16'sd1024, 16'sd205, 8, 0, 56, 110);
    random_phase(1'b1, ModeStandard, -16'sd32768, 16'sd32767, 0, 24, 24, 110);
    random_phase(1'b0, ModeMinusBias, value_t'($urandom()), value_t'($urandom()),
                 NearZeroWidth'($urandom_range(0, 32767)), 0, 0, 110);
    random_phase(1'b1, ModeFeature, value_t'($urandom()), value_t'($urandom()),
                 NearZeroWidth'($urandom_range(0, 32767)), 56, 0, 110);
    random_phase(1'b1, ModeSpare, 16'sd4096, 16'sd4096, 15'h7fff, 0, 56, 110);
    random_phase(1'b1, ModeMinusBias, 16'sd32767, -16'sd32768, 1, 24, 24, 55);
    // sender holds off until the pipeline has emptied, then resumes
    wait_drained();
    push_random(55);

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("neuron_adaptation_unit regression: pass");
    end else begin
      $display("neuron_adaptation_unit regression: fail");
    end
    $finish;
  end

endmodule
